// ===== src/pcs_pkg.sv =====
// ----------------------------------------------------------------------------
// pcs_pkg
// Types, constants and the color remap shared by the pipe color code stripper.
// ----------------------------------------------------------------------------
package pcs_pkg;

    localparam logic [7:0] PIPE_CHAR  = 8'h7C;
    localparam logic [7:0] ZERO_CHAR  = 8'h30;
    localparam logic [7:0] NINE_CHAR  = 8'h39;
    localparam logic [4:0] DEF_COLOR  = 5'd16;
    localparam logic [6:0] MAX_CODE   = 7'd31;
    localparam logic [6:0] BG_BASE    = 7'd16;

    // DOS palette order to terminal palette order
    localparam logic [2:0] DOS_TO_TERM [8] = '{3'd0, 3'd4, 3'd2, 3'd6,
                                               3'd1, 3'd5, 3'd3, 3'd7};

    typedef enum logic [1:0] {
        KIND_TEXT = 2'd0,
        KIND_RUN  = 2'd1,
        KIND_END  = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        HOLD_NONE  = 2'd0,
        HOLD_PIPE  = 2'd1,
        HOLD_DIGIT = 2'd2
    } t_hold;

    // One classified item: optional color change, up to three text bytes,
    // optional end marker, in that order.
    typedef struct packed {
        logic            run;
        logic [11:0]     pos;
        logic [4:0]      fore;
        logic [4:0]      back;
        logic [1:0]      n_text;
        logic [2:0][7:0] text;
        logic            fin;
    } t_cmd;

    localparam int CMD_W = $bits(t_cmd);

endpackage

// ===== src/pcs_front.sv =====
// ----------------------------------------------------------------------------
// pcs_front
// Parses pipe codes, tracks colors and text offset, emits one command per item.
// ----------------------------------------------------------------------------
module pcs_front
    import pcs_pkg::*;
#(
    parameter int MAX_LINE = 4096
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_take,
    input  logic [7:0] i_char,
    input  logic       i_end,
    output logic       o_push,
    output t_cmd       o_cmd
);

    localparam int OFF_W = $clog2(MAX_LINE);
    localparam logic [OFF_W+1:0] OFF_MAX = (OFF_W + 2)'(MAX_LINE - 1);

    t_hold            r_hold, n_hold;
    logic [3:0]       r_digit, n_digit;
    logic [4:0]       r_fore, n_fore;
    logic [4:0]       r_back, n_back;
    logic             r_pend, n_pend;
    logic [OFF_W-1:0] r_off, n_off;

    logic       is_dig;
    logic [3:0] dval;
    logic [6:0] code;
    logic       plain_hold;
    logic [OFF_W+1:0] off_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold  <= HOLD_NONE;
            r_digit <= '0;
            r_fore  <= DEF_COLOR;
            r_back  <= DEF_COLOR;
            r_pend  <= 1'b0;
            r_off   <= '0;
        end else if (i_take) begin
            r_hold  <= n_hold;
            r_digit <= n_digit;
            r_fore  <= n_fore;
            r_back  <= n_back;
            r_pend  <= n_pend;
            r_off   <= n_off;
        end
    end

    always_comb begin
        is_dig     = (i_char >= ZERO_CHAR) && (i_char <= NINE_CHAR);
        dval       = 4'(i_char - ZERO_CHAR);
        code       = {r_digit, 3'b000} + {2'b00, r_digit, 1'b0} + {3'b000, dval};
        plain_hold = (i_char == PIPE_CHAR) && !i_end;

        n_hold  = HOLD_NONE;
        n_digit = r_digit;
        n_fore  = r_fore;
        n_back  = r_back;
        n_pend  = r_pend;
        o_cmd   = '0;

        unique case (r_hold)
            HOLD_NONE: begin
                if (plain_hold) begin
                    n_hold = HOLD_PIPE;
                end else begin
                    o_cmd.text[0] = i_char;
                    o_cmd.n_text  = 2'd1;
                end
            end
            HOLD_PIPE: begin
                o_cmd.text[0] = PIPE_CHAR;
                if (is_dig && !i_end) begin
                    o_cmd.text[0] = '0;
                    n_hold        = HOLD_DIGIT;
                    n_digit       = dval;
                end else if (!is_dig && plain_hold) begin
                    n_hold       = HOLD_PIPE;
                    o_cmd.n_text = 2'd1;
                end else begin
                    o_cmd.text[1] = i_char;
                    o_cmd.n_text  = 2'd2;
                end
            end
            HOLD_DIGIT: begin
                if (is_dig && code <= MAX_CODE) begin
                    // complete code: apply, the change waits for the next text byte
                    if (code < BG_BASE) begin
                        n_fore = {1'b0, code[3], DOS_TO_TERM[code[2:0]]};
                    end else begin
                        n_back = {1'b0, code[3], DOS_TO_TERM[code[2:0]]};
                    end
                    n_pend = 1'b1;
                end else begin
                    o_cmd.text[0] = PIPE_CHAR;
                    o_cmd.text[1] = ZERO_CHAR + {4'h0, r_digit};
                    if (!is_dig && plain_hold) begin
                        n_hold       = HOLD_PIPE;
                        o_cmd.n_text = 2'd2;
                    end else begin
                        o_cmd.text[2] = i_char;
                        o_cmd.n_text  = 2'd3;
                    end
                end
            end
            default: begin
                n_hold = HOLD_NONE;
            end
        endcase

        // pending change goes out just ahead of the first text byte
        if (o_cmd.n_text != 2'd0 && r_pend) begin
            o_cmd.run  = 1'b1;
            o_cmd.pos  = 12'(r_off);
            o_cmd.fore = r_fore;
            o_cmd.back = r_back;
            n_pend     = 1'b0;
        end

        off_sum = {2'b00, r_off} + {OFF_W'(0), o_cmd.n_text};
        n_off   = (off_sum > OFF_MAX) ? OFF_MAX[OFF_W-1:0] : off_sum[OFF_W-1:0];

        o_cmd.fin = i_end;
        if (i_end) begin
            n_hold  = HOLD_NONE;
            n_digit = '0;
            n_fore  = DEF_COLOR;
            n_back  = DEF_COLOR;
            n_pend  = 1'b0;
            n_off   = '0;
        end

        o_push = i_take && (o_cmd.fin || o_cmd.n_text != 2'd0);
    end

endmodule

// ===== src/pcs_queue.sv =====
// ----------------------------------------------------------------------------
// pcs_queue
// Two-entry command queue between parser and result sequencer.
// ----------------------------------------------------------------------------
module pcs_queue
    import pcs_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output logic o_full,
    output logic o_valid,
    output t_cmd o_cmd
);

    t_cmd       r_mem [2];
    logic       r_wptr, r_rptr;
    logic [1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= ~r_wptr;
            end
            if (i_pop) begin
                r_rptr <= ~r_rptr;
            end
            r_count <= r_count + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_cmd   = r_mem[r_rptr];

endmodule

// ===== src/pcs_back.sv =====
// ----------------------------------------------------------------------------
// pcs_back
// Expands each command into registered result items, one per cycle unless stalled.
// ----------------------------------------------------------------------------
module pcs_back
    import pcs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_cmd        i_cmd,
    output logic        o_pop,
    input  logic        i_ready,
    output logic        o_valid,
    output t_kind       o_kind,
    output logic [7:0]  o_char,
    output logic [11:0] o_pos,
    output logic [4:0]  o_fore,
    output logic [4:0]  o_back,
    output logic        o_last
);

    logic [2:0]  r_step;
    logic        r_valid;
    t_kind       r_kind, n_kind;
    logic [7:0]  r_char, n_char;
    logic [11:0] r_pos, n_pos;
    logic [4:0]  r_fore, n_fore;
    logic [4:0]  r_back, n_back;
    logic        r_last, n_last;

    logic       load;
    logic [2:0] total;
    logic [2:0] tidx;

    always_comb begin
        load  = i_valid && (!r_valid || i_ready);
        total = {2'b00, i_cmd.run} + {1'b0, i_cmd.n_text} + {2'b00, i_cmd.fin};
        tidx  = r_step - {2'b00, i_cmd.run};
        n_kind = KIND_END;
        n_char = '0;
        n_pos  = '0;
        n_fore = '0;
        n_back = '0;
        priority if (i_cmd.run && r_step == 3'd0) begin
            n_kind = KIND_RUN;
            n_pos  = i_cmd.pos;
            n_fore = i_cmd.fore;
            n_back = i_cmd.back;
        end else if (tidx < {1'b0, i_cmd.n_text}) begin
            n_kind = KIND_TEXT;
            n_char = i_cmd.text[tidx[1:0]];
        end else begin
            n_kind = KIND_END;
        end
        n_last = (r_step == total - 3'd1);
        o_pop  = load && n_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= 3'd0;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_step <= n_last ? 3'd0 : r_step + 3'd1;
            end
            if (load) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_kind <= n_kind;
            r_char <= n_char;
            r_pos  <= n_pos;
            r_fore <= n_fore;
            r_back <= n_back;
            r_last <= n_last;
        end
    end

    assign o_valid = r_valid;
    assign o_kind  = r_kind;
    assign o_char  = r_char;
    assign o_pos   = r_pos;
    assign o_fore  = r_fore;
    assign o_back  = r_back;
    assign o_last  = r_last;

endmodule

// ===== src/pipe_color_code_stripper.sv =====
// ----------------------------------------------------------------------------
// pipe_color_code_stripper
// Strips pipe color codes from a line of text and emits color change runs.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel: one byte per transfer in s_tdata, s_tlast on the line's
//   final byte. Master channel: result items; m_tuser gives the kind (text,
//   color change, end of line), m_tlast marks the last result of one input.
//   A pipe plus two digits with value up to 31 becomes a color change that is
//   sent just ahead of the next text byte; other bytes pass through as text.
//   Pipeline: the parser writes the queue at the input transfer edge and the
//   output register loads from the queue once the output is free. Throughput:
//   the result sequencer sends one result per cycle while m_tready is high, so
//   an input holds it for as many results as it causes (plain text one, a
//   failed code with a pending change and line end up to five); the parser
//   takes a byte every cycle while the two-entry queue has room.
//   Reset (synchronous, active low) clears the held code, colors to default,
//   the offset, queue and output register. When the receiver stalls, the
//   output register holds its result, the queue fills and s_tready drops.
// ----------------------------------------------------------------------------
module pipe_color_code_stripper
    import pcs_pkg::*;
#(
    parameter int MAX_LINE = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave side
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_in
    input  logic        s_tlast,   // line_end
    // master side
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [7:0] char_out, [19:8] run_position,
                                   // [24:20] fore, [29:25] back, [31:30] zero
    output logic [1:0]  m_tuser,   // [1:0] kind
    output logic        m_tlast    // run_last
);

    logic  take;
    logic  push;
    logic  pop;
    logic  q_full;
    logic  q_valid;
    t_cmd  f_cmd;
    t_cmd  q_cmd;
    t_kind kind;
    logic [7:0]  char_out;
    logic [11:0] run_pos;
    logic [4:0]  fore;
    logic [4:0]  back;

    // accept a byte whenever the queue has a free slot
    assign s_tready = !q_full;
    assign take     = s_tvalid && s_tready;

    pcs_front #(
        .MAX_LINE(MAX_LINE)
    ) u_front (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_take (take),
        .i_char (s_tdata),
        .i_end  (s_tlast),
        .o_push (push),
        .o_cmd  (f_cmd)
    );

    pcs_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_cmd  (f_cmd),
        .i_pop  (pop),
        .o_full (q_full),
        .o_valid(q_valid),
        .o_cmd  (q_cmd)
    );

    pcs_back u_back (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(q_valid),
        .i_cmd  (q_cmd),
        .o_pop  (pop),
        .i_ready(m_tready),
        .o_valid(m_tvalid),
        .o_kind (kind),
        .o_char (char_out),
        .o_pos  (run_pos),
        .o_fore (fore),
        .o_back (back),
        .o_last (m_tlast)
    );

    // pack result fields, lowest field first
    assign m_tdata = {2'b00, back, fore, run_pos, char_out};
    assign m_tuser = kind;

endmodule
